>>> rtl/hrp_pkg.sv
// Shared types, state codes and byte-class helpers for the HTTP request parser.
// Used by hrp_step and by the http_request_header_parser top level.
// No dependencies.
package hrp_pkg;

  // Parser states, one-hot
  typedef enum logic [19:0] {
    ST_METHOD_START = 20'h00001,
    ST_METHOD       = 20'h00002,
    ST_URI          = 20'h00004,
    ST_VER_H        = 20'h00008,
    ST_VER_T1       = 20'h00010,
    ST_VER_T2       = 20'h00020,
    ST_VER_P        = 20'h00040,
    ST_VER_SLASH    = 20'h00080,
    ST_MAJ_FIRST    = 20'h00100,
    ST_MAJ_MORE     = 20'h00200,
    ST_MIN_FIRST    = 20'h00400,
    ST_MIN_MORE     = 20'h00800,
    ST_LF_REQLINE   = 20'h01000,
    ST_LINE_BEGIN   = 20'h02000,
    ST_FOLD         = 20'h04000,
    ST_NAME         = 20'h08000,
    ST_GAP          = 20'h10000,
    ST_VALUE        = 20'h20000,
    ST_LF_HEADER    = 20'h40000,
    ST_LF_FINAL     = 20'h80000
  } state_e;

  // Per-byte status
  typedef enum logic [1:0] {
    STATUS_MORE = 2'd0,
    STATUS_DONE = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

  // Which part of the request a byte belongs to
  typedef enum logic [2:0] {
    PART_DELIM  = 3'd0,
    PART_METHOD = 3'd1,
    PART_URI    = 3'd2,
    PART_NAME   = 3'd3,
    PART_VALUE  = 3'd4
  } part_e;

  // Byte values the parser looks for
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam logic [7:0] CtlMax  = 8'h1F;
  localparam logic [15:0] VerSat = 16'hFFFF;

  // Architectural parser state
  typedef struct packed {
    state_e      state;
    logic        header_seen;
    logic [15:0] major;
    logic [15:0] minor;
  } parse_t;

  localparam parse_t ParseReset = '{
    state:       ST_METHOD_START,
    header_seen: 1'b0,
    major:       16'd0,
    minor:       16'd0
  };

  // One result word
  typedef struct packed {
    status_e     status;
    part_e       part;
    logic        new_header;
    logic [7:0]  byte_echo;
    logic [15:0] major;
    logic [15:0] minor;
  } result_t;

  function automatic logic is_ctl(input logic [7:0] b);
    return (b <= CtlMax) || (b == ChDel);
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    logic sep;
    case (b) inside
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return sep;
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    return !b[7] && !is_ctl(b) && !is_sep(b);
  endfunction

  function automatic logic is_dec_char(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // acc * 10 + digit, saturating; only used on digit bytes
  function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] b);
    logic [19:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, b[3:0]};
    return (v > {4'd0, VerSat}) ? VerSat : v[15:0];
  endfunction

endpackage

>>> rtl/http_request_header_parser.sv
// HTTP/1.x request header parser, one byte per word, with output skid buffer.
// Depends on hrp_pkg and hrp_step.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_ready_o | data_byte_i, restart_i
//   out     | output    | out_valid_o/out_ready_i | status_o, part_o, new_header_o,
//           |           |                      | byte_echo_o, version_major_o/minor_o
//
// Throughput is one word per cycle while the skid entry is empty; results are registered.
// The parser state register closes the only loop, through one step of logic.
// A two-entry output (result register plus skid register) keeps in_ready_o a
// registered signal; input stalls only when both entries are full.
// Reset (rst_ni low, asynchronous) returns the parser to method start.
module http_request_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [2:0]  part_o,
  output logic        new_header_o,
  output logic [7:0]  byte_echo_o,
  output logic [15:0] version_major_o,
  output logic [15:0] version_minor_o
);
  import hrp_pkg::*;

  parse_t  parse_q, parse_d;
  parse_t  step_nxt;
  result_t step_res;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    in_fire;
  logic    out_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  hrp_step u_step (
    .cur_i    (parse_q),
    .data_i   (data_byte_i),
    .restart_i(restart_i),
    .nxt_o    (step_nxt),
    .res_o    (step_res)
  );

  // Advance parser state on each accepted word
  assign parse_d = in_fire ? step_nxt : parse_q;

  // Steer results into the result or skid register
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = step_res;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = step_res;
      skid_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q      <= ParseReset;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      parse_q      <= parse_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign part_o          = out_q.part;
  assign new_header_o    = out_q.new_header;
  assign byte_echo_o     = out_q.byte_echo;
  assign version_major_o = out_q.major;
  assign version_minor_o = out_q.minor;

  // Skid entry is only ever filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while result register empty");

  // A syntax error without restart leaves the parser state untouched
  a_err_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !restart_i && (step_res.status == STATUS_BAD)) |=>
      (parse_q == $past(parse_q)))
    else $error("parser state changed on a syntax error");

  // Completion is only reported from the final line feed state
  a_done_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (step_res.status == STATUS_DONE)) |=> (parse_q.state == ST_LF_FINAL))
    else $error("request complete outside final state");

  // A new header flag goes with a header name byte
  a_new_hdr_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.new_header) |-> (out_q.part == PART_NAME))
    else $error("new header flag on a non-name byte");

endmodule

>>> rtl/hrp_step.sv
// One parser step: next state and result word for one request byte.
// Pure combinational; depends on hrp_pkg.
module hrp_step (
  input  hrp_pkg::parse_t  cur_i,
  input  logic [7:0]       data_i,
  input  logic             restart_i,
  output hrp_pkg::parse_t  nxt_o,
  output hrp_pkg::result_t res_o
);
  import hrp_pkg::*;

  parse_t      eff;
  parse_t      nxt;
  status_e     status;
  part_e       part;
  logic        fresh;
  logic        tok;
  logic        ctl;
  logic        dig;
  logic        blank;
  logic [15:0] maj_next;
  logic [15:0] min_next;

  // Classify the byte and precompute the version digit updates
  assign eff      = restart_i ? ParseReset : cur_i;
  assign tok      = is_token(data_i);
  assign ctl      = is_ctl(data_i);
  assign dig      = is_dec_char(data_i);
  assign blank    = (data_i == ChSp) || (data_i == ChTab);
  assign maj_next = acc_digit(eff.major, data_i);
  assign min_next = acc_digit(eff.minor, data_i);

  // Advance the state machine
  always_comb begin
    nxt    = eff;
    status = STATUS_MORE;
    part   = PART_DELIM;
    fresh  = 1'b0;
    unique case (eff.state)
      ST_METHOD_START: begin
        if (tok) begin
          nxt.state = ST_METHOD;
          part      = PART_METHOD;
        end else status = STATUS_BAD;
      end
      ST_METHOD: begin
        if (data_i == ChSp) nxt.state = ST_URI;
        else if (tok) part = PART_METHOD;
        else status = STATUS_BAD;
      end
      ST_URI: begin
        if (data_i == ChSp) nxt.state = ST_VER_H;
        else if (ctl) status = STATUS_BAD;
        else part = PART_URI;
      end
      ST_VER_H: begin
        if (data_i == ChH) nxt.state = ST_VER_T1;
        else status = STATUS_BAD;
      end
      ST_VER_T1: begin
        if (data_i == ChT) nxt.state = ST_VER_T2;
        else status = STATUS_BAD;
      end
      ST_VER_T2: begin
        if (data_i == ChT) nxt.state = ST_VER_P;
        else status = STATUS_BAD;
      end
      ST_VER_P: begin
        if (data_i == ChP) nxt.state = ST_VER_SLASH;
        else status = STATUS_BAD;
      end
      ST_VER_SLASH: begin
        if (data_i == ChSlash) begin
          nxt.major = 16'd0;
          nxt.minor = 16'd0;
          nxt.state = ST_MAJ_FIRST;
        end else status = STATUS_BAD;
      end
      ST_MAJ_FIRST: begin
        if (dig) begin
          nxt.major = maj_next;
          nxt.state = ST_MAJ_MORE;
        end else status = STATUS_BAD;
      end
      ST_MAJ_MORE: begin
        if (data_i == ChDot) nxt.state = ST_MIN_FIRST;
        else if (dig) nxt.major = maj_next;
        else status = STATUS_BAD;
      end
      ST_MIN_FIRST: begin
        if (dig) begin
          nxt.minor = min_next;
          nxt.state = ST_MIN_MORE;
        end else status = STATUS_BAD;
      end
      ST_MIN_MORE: begin
        if (data_i == ChCr) nxt.state = ST_LF_REQLINE;
        else if (dig) nxt.minor = min_next;
        else status = STATUS_BAD;
      end
      ST_LF_REQLINE: begin
        if (data_i == ChLf) nxt.state = ST_LINE_BEGIN;
        else status = STATUS_BAD;
      end
      ST_LINE_BEGIN: begin
        if (data_i == ChCr) nxt.state = ST_LF_FINAL;
        else if (eff.header_seen && blank) nxt.state = ST_FOLD;
        else if (tok) begin
          nxt.header_seen = 1'b1;
          nxt.state       = ST_NAME;
          fresh           = 1'b1;
          part            = PART_NAME;
        end else status = STATUS_BAD;
      end
      ST_FOLD: begin
        if (data_i == ChCr) nxt.state = ST_LF_HEADER;
        else if (blank) nxt.state = ST_FOLD;
        else if (ctl) status = STATUS_BAD;
        else begin
          nxt.state = ST_VALUE;
          part      = PART_VALUE;
        end
      end
      ST_NAME: begin
        if (data_i == ChColon) nxt.state = ST_GAP;
        else if (tok) part = PART_NAME;
        else status = STATUS_BAD;
      end
      ST_GAP: begin
        if (data_i == ChSp) nxt.state = ST_VALUE;
        else status = STATUS_BAD;
      end
      ST_VALUE: begin
        if (data_i == ChCr) nxt.state = ST_LF_HEADER;
        else if (ctl) status = STATUS_BAD;
        else part = PART_VALUE;
      end
      ST_LF_HEADER: begin
        if (data_i == ChLf) nxt.state = ST_LINE_BEGIN;
        else status = STATUS_BAD;
      end
      ST_LF_FINAL: begin
        if (data_i == ChLf) status = STATUS_DONE;
        else status = STATUS_BAD;
      end
      default: status = STATUS_BAD;
    endcase

    // Hold state and drop the tag on a syntax error
    if (status == STATUS_BAD) begin
      nxt   = eff;
      part  = PART_DELIM;
      fresh = 1'b0;
    end
  end

  assign nxt_o = nxt;
  assign res_o = '{
    status:     status,
    part:       part,
    new_header: fresh,
    byte_echo:  data_i,
    major:      nxt.major,
    minor:      nxt.minor
  };

endmodule
